[rtl/core/piecewise_linear_forward_curve_macros.svh]
`ifndef PIECEWISE_LINEAR_FORWARD_CURVE_MACROS_SVH
`define PIECEWISE_LINEAR_FORWARD_CURVE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PLFC_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PLFC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[rtl/core/plfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package plfc_pkg;

    localparam int MAX_KNOTS_DEF = 64;
    localparam int TIME_W        = 24;
    localparam int RATE_W        = 32;
    localparam int ENTRY_W       = TIME_W + 2 * RATE_W;
    localparam int DIV_W         = 64;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic signed [63:0] QLIM     = 64'sd70368744177664;
    localparam logic signed [63:0] RATE_MAX = 64'sd2147483647;
    localparam logic signed [63:0] RATE_MIN = -64'sd2147483648;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_ORDER = 3'd3,
        ST_SAT   = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        C_NONE,
        C_LOAD,
        C_CLEAR,
        C_SET_FULL,
        C_SET_ORDER,
        C_SET_EMPTY,
        C_SET_NOP,
        C_FIRST,
        C_MUL_YT,
        C_MUL_YPTP,
        C_MUL_DC,
        C_NUM,
        C_DIV_NUM,
        C_CLAMP_Q,
        C_DIV_Q,
        C_SET_A,
        C_MUL_ATP,
        C_SET_B,
        C_MUL_AT,
        C_SET_E,
        C_WRITE,
        C_SRCH_INIT,
        C_RD_MID,
        C_SRCH_STEP,
        C_RD_LO,
        C_SET_END,
        C_MUL_Q,
        C_SET_Q,
        C_DONE
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       count_zero;
        logic       full;
        logic       order_bad;
        logic       div_done;
        logic       srch_open;
        logic       lo_at_end;
        logic       out_free;
    } dp_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > RATE_MAX)
            r = RATE_MAX;
        else if (v < RATE_MIN)
            r = RATE_MIN;
        else
            r = v;
        return r[31:0];
    endfunction

    function automatic logic is_sat32(input logic signed [63:0] v);
        return (v > RATE_MAX) || (v < RATE_MIN);
    endfunction

endpackage
`default_nettype wire

[rtl/core/plfc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface plfc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [23:0]        knot_maturity;
    logic signed [31:0] knot_yield;
    logic [23:0]        query_time;

    modport source (output valid, output op, output knot_maturity, output knot_yield,
                    output query_time, input ready);
    modport sink (input valid, input op, input knot_maturity, input knot_yield,
                  input query_time, output ready);
endinterface

interface plfc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] forward_rate;
    logic [2:0]         status;

    modport source (output valid, output forward_rate, output status, input ready);
    modport sink (input valid, input forward_rate, input status, output ready);
endinterface
`default_nettype wire

[rtl/core/plfc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module plfc_ram #(
    parameter int WIDTH = plfc_pkg::ENTRY_W,
    parameter int DEPTH = plfc_pkg::MAX_KNOTS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/core/plfc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module plfc_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic signed [plfc_pkg::DIV_W-1:0] dividend,
    input  wire logic [plfc_pkg::TIME_W-1:0]      divisor,
    output logic signed [plfc_pkg::DIV_W-1:0]     quotient,
    output logic                                  done
);
    localparam int N  = plfc_pkg::DIV_W;
    localparam int DW = plfc_pkg::TIME_W;
    localparam int NW = $clog2(N);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          neg_reg, neg_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [N-1:0]  quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   rem_sh;
    logic          fits;

    // One quotient bit a cycle, restoring, on magnitudes.
    assign rem_sh = {rem_reg, quo_reg[N-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[N-1];
            quo_next  = dividend[N-1] ? N'(-dividend) : N'(dividend);
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
            quo_next = {quo_reg[N-2:0], fits};
            cnt_next = cnt_reg + NW'(1);
            if (cnt_reg == NW'(N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign done     = done_reg;
endmodule
`default_nettype wire

[rtl/core/plfc_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module plfc_dp #(
    parameter int MAX_KNOTS = plfc_pkg::MAX_KNOTS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire plfc_pkg::cmd_t       cmd,
    output plfc_pkg::dp_status_t      st,
    input  wire logic [1:0]           in_op,
    input  wire logic [23:0]          in_maturity,
    input  wire logic signed [31:0]   in_yield,
    input  wire logic [23:0]          in_time,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [31:0]        out_rate,
    output logic [2:0]                out_status
);
    localparam int AW = $clog2(MAX_KNOTS);
    localparam int CW = $clog2(MAX_KNOTS + 1);
    localparam int EW = plfc_pkg::ENTRY_W;

    logic [1:0]         op_reg;
    logic [23:0]        t_reg, x_reg, prev_time_reg;
    logic signed [31:0] y_reg, prev_y_reg, prev_e_reg;
    logic [CW-1:0]      count_reg, lo_reg, hi_reg;
    logic signed [59:0] acc_reg;
    logic signed [56:0] prod_reg;
    logic signed [47:0] q_reg;
    logic signed [31:0] a_reg, b_reg, rate_reg, out_rate_reg;
    logic               sat_reg, out_valid_reg;
    logic [2:0]         status_reg, out_status_reg;

    logic signed [31:0] ma;
    logic [23:0]        mb;
    logic signed [56:0] mul;
    logic signed [40:0] prod_sh;
    logic signed [63:0] prod_sh64;
    logic [23:0]        d;
    logic               div_start, div_done;
    logic signed [63:0] div_dividend, quot;
    logic signed [63:0] b_val, e_val, q_val;
    logic [CW:0]        mid_sum;
    logic [CW-1:0]      mid;
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [EW-1:0]      ram_wdata, ram_rdata;
    logic [23:0]        rd_time;
    logic signed [31:0] rd_slope, rd_icpt;

    assign d         = t_reg - prev_time_reg;
    assign rd_time   = ram_rdata[EW-1 -: 24];
    assign rd_slope  = $signed(ram_rdata[63:32]);
    assign rd_icpt   = $signed(ram_rdata[31:0]);
    assign prod_sh   = $signed(prod_reg[56:16]);
    assign prod_sh64 = {{23{prod_sh[40]}}, prod_sh};
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[CW:1];

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd)
            plfc_pkg::C_MUL_YT:
            begin
                ma = y_reg;
                mb = t_reg;
            end
            plfc_pkg::C_MUL_YPTP:
            begin
                ma = prev_y_reg;
                mb = prev_time_reg;
            end
            plfc_pkg::C_MUL_DC:
            begin
                ma = prev_e_reg;
                mb = d;
            end
            plfc_pkg::C_MUL_ATP:
            begin
                ma = a_reg;
                mb = prev_time_reg;
            end
            plfc_pkg::C_MUL_AT:
            begin
                ma = a_reg;
                mb = t_reg;
            end
            plfc_pkg::C_MUL_Q:
            begin
                ma = rd_slope;
                mb = x_reg;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign mul = ma * $signed({1'b0, mb});

    assign div_start    = (cmd == plfc_pkg::C_DIV_NUM) || (cmd == plfc_pkg::C_DIV_Q);
    assign div_dividend = (cmd == plfc_pkg::C_DIV_Q) ? {q_reg, 16'b0}
                                                      : {{4{acc_reg[59]}}, acc_reg};

    plfc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (d),
        .quotient (quot),
        .done     (div_done)
    );

    assign b_val = {{32{prev_e_reg[31]}}, prev_e_reg} - prod_sh64;
    assign e_val = prod_sh64 + {{32{b_reg[31]}}, b_reg};
    assign q_val = prod_sh64 + {{32{b_reg[31]}}, b_reg};

    assign ram_we    = (cmd == plfc_pkg::C_FIRST) || (cmd == plfc_pkg::C_WRITE);
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = (cmd == plfc_pkg::C_FIRST) ? {t_reg, 32'b0, y_reg}
                                                   : {t_reg, a_reg, b_reg};
    assign ram_re    = (cmd == plfc_pkg::C_RD_MID) || (cmd == plfc_pkg::C_RD_LO);
    assign ram_raddr = (cmd == plfc_pkg::C_RD_MID) ? mid[AW-1:0] : lo_reg[AW-1:0];

    plfc_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_KNOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            prev_y_reg    <= '0;
            prev_e_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd)
                plfc_pkg::C_CLEAR:
                begin
                    count_reg  <= '0;
                    prev_y_reg <= '0;
                    prev_e_reg <= '0;
                end
                plfc_pkg::C_FIRST:
                begin
                    count_reg  <= CW'(1);
                    prev_y_reg <= y_reg;
                    prev_e_reg <= y_reg;
                end
                plfc_pkg::C_SET_E:
                begin
                    prev_e_reg <= plfc_pkg::sat32(e_val);
                end
                plfc_pkg::C_WRITE:
                begin
                    count_reg  <= count_reg + CW'(1);
                    prev_y_reg <= y_reg;
                end
                default:
                begin
                end
            endcase
            if (cmd == plfc_pkg::C_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul;
        case (cmd)
            plfc_pkg::C_LOAD:
            begin
                op_reg  <= in_op;
                t_reg   <= in_maturity;
                y_reg   <= in_yield;
                x_reg   <= in_time;
                sat_reg <= 1'b0;
            end
            plfc_pkg::C_CLEAR, plfc_pkg::C_SET_NOP:
            begin
                rate_reg   <= '0;
                status_reg <= plfc_pkg::ST_OK;
            end
            plfc_pkg::C_SET_FULL:
            begin
                rate_reg   <= '0;
                status_reg <= plfc_pkg::ST_FULL;
            end
            plfc_pkg::C_SET_ORDER:
            begin
                rate_reg   <= '0;
                status_reg <= plfc_pkg::ST_ORDER;
            end
            plfc_pkg::C_SET_EMPTY:
            begin
                rate_reg   <= '0;
                status_reg <= plfc_pkg::ST_EMPTY;
            end
            plfc_pkg::C_FIRST:
            begin
                prev_time_reg <= t_reg;
                rate_reg      <= '0;
                status_reg    <= plfc_pkg::ST_OK;
            end
            plfc_pkg::C_MUL_YPTP:
            begin
                acc_reg <= {{3{prod_reg[56]}}, prod_reg};
            end
            plfc_pkg::C_MUL_DC:
            begin
                acc_reg <= acc_reg - {{3{prod_reg[56]}}, prod_reg};
            end
            plfc_pkg::C_NUM:
            begin
                acc_reg <= (acc_reg - {{3{prod_reg[56]}}, prod_reg}) <<< 1;
            end
            plfc_pkg::C_CLAMP_Q:
            begin
                if (quot > plfc_pkg::QLIM)
                    q_reg <= plfc_pkg::QLIM[47:0];
                else if (quot < -plfc_pkg::QLIM)
                    q_reg <= 48'(-plfc_pkg::QLIM);
                else
                    q_reg <= quot[47:0];
            end
            plfc_pkg::C_SET_A:
            begin
                a_reg   <= plfc_pkg::sat32(quot);
                sat_reg <= sat_reg | plfc_pkg::is_sat32(quot);
            end
            plfc_pkg::C_SET_B:
            begin
                b_reg   <= plfc_pkg::sat32(b_val);
                sat_reg <= sat_reg | plfc_pkg::is_sat32(b_val);
            end
            plfc_pkg::C_SET_E:
            begin
                sat_reg <= sat_reg | plfc_pkg::is_sat32(e_val);
            end
            plfc_pkg::C_WRITE:
            begin
                prev_time_reg <= t_reg;
                rate_reg      <= '0;
                status_reg    <= sat_reg ? plfc_pkg::ST_SAT : plfc_pkg::ST_OK;
            end
            plfc_pkg::C_SRCH_INIT:
            begin
                lo_reg <= '0;
                hi_reg <= count_reg;
            end
            plfc_pkg::C_SRCH_STEP:
            begin
                if (x_reg <= rd_time)
                    hi_reg <= mid;
                else
                    lo_reg <= mid + CW'(1);
            end
            plfc_pkg::C_SET_END:
            begin
                rate_reg   <= prev_e_reg;
                status_reg <= plfc_pkg::ST_OK;
            end
            plfc_pkg::C_MUL_Q:
            begin
                b_reg <= rd_icpt;
            end
            plfc_pkg::C_SET_Q:
            begin
                rate_reg   <= plfc_pkg::sat32(q_val);
                status_reg <= plfc_pkg::is_sat32(q_val) ? plfc_pkg::ST_SAT : plfc_pkg::ST_OK;
            end
            plfc_pkg::C_DONE:
            begin
                out_rate_reg   <= rate_reg;
                out_status_reg <= status_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign st.op         = op_reg;
    assign st.count_zero = count_reg == '0;
    assign st.full       = count_reg == CW'(MAX_KNOTS);
    assign st.order_bad  = t_reg <= prev_time_reg;
    assign st.div_done   = div_done;
    assign st.srch_open  = lo_reg < hi_reg;
    assign st.lo_at_end  = lo_reg == count_reg;
    assign st.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_rate   = out_rate_reg;
    assign out_status = out_status_reg;
endmodule
`default_nettype wire

[rtl/core/plfc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module plfc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire plfc_pkg::dp_status_t st,
    output plfc_pkg::cmd_t            cmd
);
    typedef enum logic [18:0] {
        S_IDLE     = 19'b0000000000000000001,
        S_DISPATCH = 19'b0000000000000000010,
        S_NUM1     = 19'b0000000000000000100,
        S_NUM2     = 19'b0000000000000001000,
        S_NUM3     = 19'b0000000000000010000,
        S_DIV1     = 19'b0000000000000100000,
        S_DIV1W    = 19'b0000000000001000000,
        S_DIV2     = 19'b0000000000010000000,
        S_DIV2W    = 19'b0000000000100000000,
        S_MULB     = 19'b0000000001000000000,
        S_SETB     = 19'b0000000010000000000,
        S_MULE     = 19'b0000000100000000000,
        S_SETE     = 19'b0000001000000000000,
        S_WR       = 19'b0000010000000000000,
        S_SR_ISSUE = 19'b0000100000000000000,
        S_SR_CMP   = 19'b0001000000000000000,
        S_QWAIT    = 19'b0010000000000000000,
        S_QEND     = 19'b0100000000000000000,
        S_DONE     = 19'b1000000000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = plfc_pkg::C_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = plfc_pkg::C_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                case (st.op)
                    plfc_pkg::OP_CLEAR:
                        cmd = plfc_pkg::C_CLEAR;
                    plfc_pkg::OP_APPEND:
                    begin
                        if (st.full)
                            cmd = plfc_pkg::C_SET_FULL;
                        else if (st.count_zero)
                            cmd = plfc_pkg::C_FIRST;
                        else if (st.order_bad)
                            cmd = plfc_pkg::C_SET_ORDER;
                        else
                        begin
                            cmd        = plfc_pkg::C_MUL_YT;
                            state_next = S_NUM1;
                        end
                    end
                    plfc_pkg::OP_QUERY:
                    begin
                        if (st.count_zero)
                            cmd = plfc_pkg::C_SET_EMPTY;
                        else
                        begin
                            cmd        = plfc_pkg::C_SRCH_INIT;
                            state_next = S_SR_ISSUE;
                        end
                    end
                    default:
                        cmd = plfc_pkg::C_SET_NOP;
                endcase
            end
            S_NUM1:
            begin
                cmd        = plfc_pkg::C_MUL_YPTP;
                state_next = S_NUM2;
            end
            S_NUM2:
            begin
                cmd        = plfc_pkg::C_MUL_DC;
                state_next = S_NUM3;
            end
            S_NUM3:
            begin
                cmd        = plfc_pkg::C_NUM;
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                cmd        = plfc_pkg::C_DIV_NUM;
                state_next = S_DIV1W;
            end
            S_DIV1W:
            begin
                if (st.div_done)
                begin
                    cmd        = plfc_pkg::C_CLAMP_Q;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                cmd        = plfc_pkg::C_DIV_Q;
                state_next = S_DIV2W;
            end
            S_DIV2W:
            begin
                if (st.div_done)
                begin
                    cmd        = plfc_pkg::C_SET_A;
                    state_next = S_MULB;
                end
            end
            S_MULB:
            begin
                cmd        = plfc_pkg::C_MUL_ATP;
                state_next = S_SETB;
            end
            S_SETB:
            begin
                cmd        = plfc_pkg::C_SET_B;
                state_next = S_MULE;
            end
            S_MULE:
            begin
                cmd        = plfc_pkg::C_MUL_AT;
                state_next = S_SETE;
            end
            S_SETE:
            begin
                cmd        = plfc_pkg::C_SET_E;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd        = plfc_pkg::C_WRITE;
                state_next = S_DONE;
            end
            S_SR_ISSUE:
            begin
                // Narrow the window until it closes on the first knot at or past the time.
                if (st.srch_open)
                begin
                    cmd        = plfc_pkg::C_RD_MID;
                    state_next = S_SR_CMP;
                end
                else if (st.lo_at_end)
                begin
                    cmd        = plfc_pkg::C_SET_END;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = plfc_pkg::C_RD_LO;
                    state_next = S_QWAIT;
                end
            end
            S_SR_CMP:
            begin
                cmd        = plfc_pkg::C_SRCH_STEP;
                state_next = S_SR_ISSUE;
            end
            S_QWAIT:
            begin
                cmd        = plfc_pkg::C_MUL_Q;
                state_next = S_QEND;
            end
            S_QEND:
            begin
                cmd        = plfc_pkg::C_SET_Q;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free.
                if (st.out_free)
                begin
                    cmd        = plfc_pkg::C_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

[rtl/core/piecewise_linear_forward_curve.sv]
`timescale 1ns / 1ps
`default_nettype none
// Piecewise-linear forward curve: clear, append knots in rising maturity, query rates.
// One item at a time; each gives one result beat, held in an output register so the
// next item is taken while a result waits. Clear, rejected appends, the first knot and
// queries on an empty curve are settled in the dispatch state. A later append makes two
// passes through the shared bit-serial divider. A query runs a binary search over the
// knot memory (one registered read per probe); a query past the last knot skips the
// final knot read.
`include "piecewise_linear_forward_curve_macros.svh"
module piecewise_linear_forward_curve #(
    parameter int MAX_KNOTS = plfc_pkg::MAX_KNOTS_DEF
) (
    input wire logic    clk,
    input wire logic    rst_n,
    plfc_in_if.sink     in_ch,
    plfc_out_if.source  out_ch
);
    plfc_pkg::cmd_t       cmd;
    plfc_pkg::dp_status_t st;

    plfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .st       (st),
        .cmd      (cmd)
    );

    plfc_dp #(
        .MAX_KNOTS (MAX_KNOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .in_op       (in_ch.op),
        .in_maturity (in_ch.knot_maturity),
        .in_yield    (in_ch.knot_yield),
        .in_time     (in_ch.query_time),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_rate    (out_ch.forward_rate),
        .out_status  (out_ch.status)
    );

    `PLFC_ASSERT_NEXT(a_one_item, in_ch.valid && in_ch.ready, !in_ch.ready, "item while busy")
    `PLFC_ASSERT_IMP(a_div_busy, st.div_done, !in_ch.ready, "divider finished while idle")
    `PLFC_ASSERT_IMP(a_done_free, cmd == plfc_pkg::C_DONE, st.out_free, "waiting beat overwritten")
endmodule
`default_nettype wire

[bench/plfc_tb_if.sv]
`timescale 1ns / 1ps
// Channel interfaces come with the RTL (plfc_if.sv); nothing further is needed here.
package plfc_tb_types;
    typedef struct packed {
        logic signed [31:0] rate;
        logic [2:0]         status;
    } curve_result_t;
endpackage

[bench/tb_piecewise_linear_forward_curve.sv]
`timescale 1ns / 1ps
module tb_piecewise_linear_forward_curve;
    import plfc_pkg::*;
    import plfc_tb_types::*;

    localparam int KNOTS = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;

    plfc_in_if  in_ch();
    plfc_out_if out_ch();

    piecewise_linear_forward_curve #(.MAX_KNOTS(KNOTS)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // curve state mirrored in the bench
    logic [23:0]        mdl_times [KNOTS];
    logic signed [31:0] mdl_slope [KNOTS];
    logic signed [31:0] mdl_icept [KNOTS];
    int                 mdl_count;
    logic signed [31:0] mdl_prev_yield;
    logic signed [31:0] mdl_end_rate;

    curve_result_t pending_results[$];
    int  mismatches;
    int  idle_cycles;
    bit  hold_off;
    int  hold_cycles;
    bit  timed_out;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic signed [63:0] floor16(input logic signed [63:0] v);
        return v >>> 16;
    endfunction

    function automatic logic signed [63:0] clip(input logic signed [63:0] v, ref bit sat);
        if (v > RATE_MAX)
        begin
            sat = 1;
            return RATE_MAX;
        end
        if (v < RATE_MIN)
        begin
            sat = 1;
            return RATE_MIN;
        end
        return v;
    endfunction

    function automatic curve_result_t predict_curve(input logic [1:0] op,
                                                    input logic [23:0] mat,
                                                    input logic signed [31:0] yld,
                                                    input logic [23:0] qt);
        curve_result_t r;
        logic signed [63:0] t, y, tp, yp, c, d, num, q, a, b, e, x;
        bit sat;
        r.rate = '0;
        r.status = ST_OK;
        sat = 0;
        t = {40'd0, mat};
        y = yld;
        x = {40'd0, qt};
        if (op == OP_CLEAR)
        begin
            mdl_count = 0;
            mdl_prev_yield = '0;
            mdl_end_rate = '0;
        end
        else if (op == OP_APPEND)
        begin
            if (mdl_count >= KNOTS)
                r.status = ST_FULL;
            else if (mdl_count == 0)
            begin
                mdl_times[0] = mat;
                mdl_slope[0] = '0;
                mdl_icept[0] = yld;
                mdl_prev_yield = yld;
                mdl_end_rate = yld;
                mdl_count = 1;
            end
            else
            begin
                tp = {40'd0, mdl_times[mdl_count-1]};
                yp = mdl_prev_yield;
                c = mdl_end_rate;
                if (t <= tp)
                    r.status = ST_ORDER;
                else
                begin
                    d = t - tp;
                    num = 2 * (y * t - yp * tp - d * c);
                    q = num / d;
                    if (q > QLIM)
                        q = QLIM;
                    if (q < -QLIM)
                        q = -QLIM;
                    a = clip((q * 65536) / d, sat);
                    b = clip(c - floor16(a * tp), sat);
                    e = clip(floor16(a * t) + b, sat);
                    mdl_times[mdl_count] = mat;
                    mdl_slope[mdl_count] = a[31:0];
                    mdl_icept[mdl_count] = b[31:0];
                    mdl_prev_yield = yld;
                    mdl_end_rate = e[31:0];
                    mdl_count++;
                    if (sat)
                        r.status = ST_SAT;
                end
            end
        end
        else if (op == OP_QUERY)
        begin
            if (mdl_count == 0)
                r.status = ST_EMPTY;
            else
            begin
                r.rate = mdl_end_rate;
                for (int j = 0; j < mdl_count; j++)
                begin
                    if (x <= {40'd0, mdl_times[j]})
                    begin
                        a = clip(floor16(64'(mdl_slope[j]) * x) + 64'(mdl_icept[j]), sat);
                        r.rate = a[31:0];
                        if (sat)
                            r.status = ST_SAT;
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 3) != 0)
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(20, 80);
        return $urandom_range(1, 4);
    endfunction

    // valid stays up between beats sent back to back; drop it for a gap
    task automatic send_item(input logic [1:0] op, input logic [23:0] mat,
                             input logic signed [31:0] yld, input logic [23:0] qt,
                             input bit gaps = 1);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.knot_maturity <= mat;
        in_ch.knot_yield <= yld;
        in_ch.query_time <= qt;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_curve(op, mat, yld, qt));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_off)
            out_ch.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            hold_cycles <= gap_len();
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        curve_result_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: rate=%0d status=%0d",
                             out_ch.forward_rate, out_ch.status);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (out_ch.forward_rate !== exp_r.rate || out_ch.status !== exp_r.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected rate=%0d status=%0d, got rate=%0d status=%0d",
                                 exp_r.rate, exp_r.status, out_ch.forward_rate, out_ch.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_yield();
        return $signed(32'($urandom_range(0, 32'h0400_0000))) - 32'sh0200_0000;
    endfunction

    // rising maturity sequence, small steps mostly
    task automatic build_curve(input int n, input logic [23:0] start, input bit wild);
        logic [23:0] t;
        t = start;
        for (int i = 0; i < n; i++)
        begin
            send_item(OP_APPEND, t, wild ? 32'($urandom) : rand_yield(), 24'($urandom));
            if (t > 24'hFF_0000)
                break;
            t = t + 24'($urandom_range(1, wild ? 24'h4_0000 : 24'h2_0000));
        end
    endtask

    task automatic test_directed();
        send_item(OP_QUERY, 24'd0, 32'sd0, 24'h00_1000);
        send_item(OP_APPEND, 24'd0, 32'sh7FFF_FFFF, 24'd0);
        send_item(OP_APPEND, 24'd0, 32'sd5, 24'd0);
        send_item(OP_APPEND, 24'd1, -32'sh8000_0000, 24'd0);
        send_item(OP_QUERY, 24'd0, 32'sd0, 24'd0);
        send_item(OP_QUERY, 24'd0, 32'sd0, 24'd1);
        send_item(OP_QUERY, 24'd0, 32'sd0, 24'hFF_FFFF);
        send_item(OP_APPEND, 24'hFF_FFFF, 32'sh7FFF_FFFF, 24'd0);
        send_item(OP_APPEND, 24'hFF_FFFF, 32'sd0, 24'd0);
        send_item(OP_QUERY, 24'd0, 32'sd0, 24'h80_0000);
        send_item(2'd3, 24'hFF_FFFF, -32'sd1, 24'hFF_FFFF);
        send_item(OP_CLEAR, 24'hAA_AAAA, 32'sh5555_5555, 24'h55_5555);
        send_item(OP_QUERY, 24'd0, 32'sd0, 24'd5);
        send_item(OP_APPEND, 24'h01_0000, 32'sh0100_0000, 24'd0);
        send_item(OP_APPEND, 24'h02_0000, 32'sh0080_0000, 24'd0);
        send_item(OP_QUERY, 24'd0, 32'sd0, 24'h01_8000);
        send_item(OP_QUERY, 24'd0, 32'sd0, 24'h03_0000);
        send_item(OP_CLEAR, 24'd0, 32'sd0, 24'd0);
    endtask

    task automatic test_full_table();
        send_item(OP_CLEAR, 24'd0, 32'sd0, 24'd0);
        for (int i = 0; i < KNOTS + 2; i++)
            send_item(OP_APPEND, 24'(i * 24'h100 + 1), rand_yield(), 24'd0, 0);
        send_item(OP_QUERY, 24'd0, 32'sd0, 24'h00_2000);
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        fork
            repeat (600) @(negedge clk);
            for (int i = 0; i < 12; i++)
                send_item(OP_QUERY, 24'd0, 32'sd0, 24'($urandom), 0);
        join_any
        hold_off = 0;
        wait fork;
    endtask

    task automatic test_random();
        int sent;
        bit wild;
        sent = 0;
        while (sent < 1900)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    send_item(2'($urandom), 24'($urandom), 32'($urandom), 24'($urandom));
                    sent++;
                end
                1, 2, 3:
                begin
                    wild = ($urandom_range(0, 3) == 0);
                    send_item(OP_CLEAR, 24'($urandom), 32'($urandom), 24'($urandom));
                    build_curve($urandom_range(1, 10), 24'($urandom_range(0, 24'h8_0000)), wild);
                    sent += 6;
                end
                default:
                begin
                    send_item(OP_QUERY, 24'($urandom), 32'($urandom),
                              ($urandom_range(0, 1)) ? 24'($urandom)
                                                     : 24'($urandom_range(0, 24'h20_0000)));
                    sent++;
                end
            endcase
        end
    endtask

    initial
    begin
        mismatches = 0;
        idle_cycles = 0;
        hold_off = 0;
        hold_cycles = 0;
        timed_out = 0;
        mdl_count = 0;
        mdl_prev_yield = '0;
        mdl_end_rate = '0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_CLEAR;
        in_ch.knot_maturity = '0;
        in_ch.knot_yield = '0;
        in_ch.query_time = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_full_table();
        test_backpressure();
        test_random();
        wait_drained();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
